FILE: design/gcm_pkg.sv
// Shared types and constants for the greedy change maker.
`default_nettype none

package gcm_pkg;

    // Fixed field widths
    localparam int DATA_W      = 32;
    localparam int NUM_SLOTS   = 8;
    localparam int SLOT_IDX_W  = 3;
    localparam int OUT_TDATA_W = 3 * DATA_W;

    // Defaults for the top-level parameters
    localparam int DEFAULT_NUM_DENOMINATIONS = 8;
    localparam int DEFAULT_AMOUNT_WIDTH      = 32;

    // Denomination values after reset: only the last slot (slot 7) holds a unit piece
    localparam logic [DATA_W-1:0] DENOM_RESET [NUM_SLOTS] = '{
        32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd1
    };

    // Division cell states
    typedef enum logic [1:0] {
        CELL_IDLE,
        CELL_DIV,
        CELL_HOLD
    } cell_state_t;

    // Result that a cell presents to the collector
    typedef struct packed {
        logic              hold;
        logic [DATA_W-1:0] denom;
        logic [DATA_W-1:0] count;
        logic [DATA_W-1:0] rem;
    } gcm_res_t;

endpackage

`default_nettype wire

FILE: design/greedy_change_maker_unit.sv
// Top level of the greedy change maker: cell chain, result collector and stream ports.
`default_nettype none

// Pays out an amount over up to eight configured denominations, slot 0 first.
// Each slot is a cell that divides the amount still owed by its denomination
// with a restoring divider, one quotient bit per cycle, and then hands the
// remainder to the next cell. A cell with a zero denomination goes straight
// to its hold state and passes the amount on unchanged. One amount is worked
// at a time; each cell divides bit-serially, and the output side can stall
// the work. Every slot with a nonzero piece count gives one beat; the final
// beat carries tlast and the amount left unpaid. When nothing is paid, one
// final beat with zero denomination and zero count is sent. Denominations
// must be written through the cfg channel only while the block is idle; the
// block itself does not enforce this.
module greedy_change_maker_unit
    import gcm_pkg::*;
#(
    parameter int NUM_DENOMINATIONS = DEFAULT_NUM_DENOMINATIONS,
    parameter int AMOUNT_WIDTH      = DEFAULT_AMOUNT_WIDTH
)
(
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  cfg_valid,
    output      logic                                  cfg_ready,
    input  wire logic [SLOT_IDX_W-1:0]                 cfg_index,
    input  wire logic [DATA_W-1:0]                     cfg_data,
    input  wire logic                                  s_axis_tvalid,
    output      logic                                  s_axis_tready,
    // amount
    input  wire logic [((AMOUNT_WIDTH+7)/8)*8-1:0]     s_axis_tdata,
    output      logic                                  m_axis_tvalid,
    input  wire logic                                  m_axis_tready,
    // denomination, piece_count, unpaid
    output      logic [OUT_TDATA_W-1:0]                m_axis_tdata,
    output      logic                                  m_axis_tlast
);

    localparam int OWED_W = (AMOUNT_WIDTH < DATA_W) ? AMOUNT_WIDTH : DATA_W;

    gcm_res_t res  [NUM_DENOMINATIONS];
    logic     ack  [NUM_DENOMINATIONS];
    gcm_res_t sel;

    logic              busy_reg,      busy_next;
    logic              pend_vld_reg,  pend_vld_next;
    logic [DATA_W-1:0] pend_denom_reg, pend_denom_next;
    logic [DATA_W-1:0] pend_count_reg, pend_count_next;
    logic              fin_reg,       fin_next;
    logic [DATA_W-1:0] fin_rem_reg,   fin_rem_next;
    logic              out_vld_reg,   out_vld_next;
    logic [DATA_W-1:0] out_denom_reg, out_denom_next;
    logic [DATA_W-1:0] out_count_reg, out_count_next;
    logic [DATA_W-1:0] out_unpaid_reg, out_unpaid_next;
    logic              out_last_reg,  out_last_next;

    logic in_beat;
    logic out_free;
    logic paid;
    logic take;

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = !busy_reg;
    assign in_beat       = s_axis_tvalid && s_axis_tready;

    // Chain of division cells: the first started by an input beat, each other by its neighbor's hand-off
    for (genvar k = 0; k < NUM_DENOMINATIONS; k++)
    begin : g_cell
        logic              start;
        logic [OWED_W-1:0] owed;

        if (k == 0)
        begin : g_head
            assign start = in_beat;
            assign owed  = s_axis_tdata[OWED_W-1:0];
        end
        else
        begin : g_link
            assign start = ack[k-1];
            assign owed  = res[k-1].rem[OWED_W-1:0];
        end

        assign ack[k] = take && res[k].hold;

        gcm_cell #(
            .OWED_W      (OWED_W),
            .RESET_DENOM (DENOM_RESET[k])
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .cfg_we   (cfg_valid && cfg_ready && (cfg_index == SLOT_IDX_W'(k))),
            .cfg_data (cfg_data),
            .start    (start),
            .owed_in  (owed),
            .ack      (ack[k]),
            .res      (res[k])
        );
    end

    // Pick the one cell that holds a finished division
    always_comb
    begin
        sel = '0;
        for (int k = 0; k < NUM_DENOMINATIONS; k++)
        begin
            if (res[k].hold)
            begin
                sel = res[k];
            end
        end
    end

    // Take a result at once if it pays nothing or none is pending, else once the held one can move out
    assign out_free = !out_vld_reg || m_axis_tready;
    assign paid     = sel.hold && (sel.count != '0);
    assign take     = sel.hold && (!paid || !pend_vld_reg || out_free);

    // Collector: hold back one paid result until the next is known, mark the final beat
    always_comb
    begin
        busy_next       = busy_reg;
        pend_vld_next   = pend_vld_reg;
        pend_denom_next = pend_denom_reg;
        pend_count_next = pend_count_reg;
        fin_next        = fin_reg;
        fin_rem_next    = fin_rem_reg;
        out_vld_next    = out_vld_reg;
        out_denom_next  = out_denom_reg;
        out_count_next  = out_count_reg;
        out_unpaid_next = out_unpaid_reg;
        out_last_next   = out_last_reg;

        if (out_vld_reg && m_axis_tready)
        begin
            out_vld_next = 1'b0;
        end

        if (in_beat)
        begin
            busy_next = 1'b1;
        end

        if (take && paid)
        begin
            if (pend_vld_reg)
            begin
                out_vld_next    = 1'b1;
                out_denom_next  = pend_denom_reg;
                out_count_next  = pend_count_reg;
                out_unpaid_next = '0;
                out_last_next   = 1'b0;
            end
            pend_vld_next   = 1'b1;
            pend_denom_next = sel.denom;
            pend_count_next = sel.count;
        end

        if (take && res[NUM_DENOMINATIONS-1].hold)
        begin
            fin_next     = 1'b1;
            fin_rem_next = sel.rem;
        end

        if (fin_reg && out_free)
        begin
            out_vld_next    = 1'b1;
            out_denom_next  = pend_vld_reg ? pend_denom_reg : '0;
            out_count_next  = pend_vld_reg ? pend_count_reg : '0;
            out_unpaid_next = fin_rem_reg;
            out_last_next   = 1'b1;
            pend_vld_next   = 1'b0;
            fin_next        = 1'b0;
            busy_next       = 1'b0;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg     <= 1'b0;
            pend_vld_reg <= 1'b0;
            fin_reg      <= 1'b0;
            out_vld_reg  <= 1'b0;
        end
        else
        begin
            busy_reg     <= busy_next;
            pend_vld_reg <= pend_vld_next;
            fin_reg      <= fin_next;
            out_vld_reg  <= out_vld_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        pend_denom_reg <= pend_denom_next;
        pend_count_reg <= pend_count_next;
        fin_rem_reg    <= fin_rem_next;
        out_denom_reg  <= out_denom_next;
        out_count_reg  <= out_count_next;
        out_unpaid_reg <= out_unpaid_next;
        out_last_reg   <= out_last_next;
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = {out_unpaid_reg, out_count_reg, out_denom_reg};
    assign m_axis_tlast  = out_last_reg;

endmodule

`default_nettype wire

FILE: design/gcm_cell.sv
// One denomination cell: holds its denomination and divides the owed amount bit-serially.
`default_nettype none

module gcm_cell
    import gcm_pkg::*;
#(
    parameter int                OWED_W      = 32,
    parameter logic [DATA_W-1:0] RESET_DENOM = '0
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_we,
    input  wire logic [DATA_W-1:0] cfg_data,
    input  wire logic              start,
    input  wire logic [OWED_W-1:0] owed_in,
    input  wire logic              ack,
    output gcm_res_t               res
);

    localparam int CNT_W = $clog2(OWED_W + 1);

    cell_state_t       state_reg, state_next;
    logic [DATA_W-1:0] denom_reg, denom_next;
    logic [DATA_W-1:0] rem_reg,   rem_next;
    logic [OWED_W-1:0] quo_reg,   quo_next;
    logic [CNT_W-1:0]  cnt_reg,   cnt_next;

    logic [DATA_W:0]   trial;
    logic              fits;

    // Trial subtraction of one restoring division step
    assign trial = {rem_reg, quo_reg[OWED_W-1]} - {1'b0, denom_reg};
    assign fits  = ({rem_reg, quo_reg[OWED_W-1]} >= {1'b0, denom_reg});

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            CELL_IDLE:
            begin
                if (start)
                begin
                    state_next = (denom_reg == '0) ? CELL_HOLD : CELL_DIV;
                end
            end
            CELL_DIV:
            begin
                if (cnt_reg == CNT_W'(1))
                begin
                    state_next = CELL_HOLD;
                end
            end
            CELL_HOLD:
            begin
                if (ack)
                begin
                    state_next = CELL_IDLE;
                end
            end
            default:
            begin
                state_next = CELL_IDLE;
            end
        endcase
    end

    // Datapath: load on start, shift one quotient bit per cycle while dividing
    always_comb
    begin
        denom_next = cfg_we ? cfg_data : denom_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        cnt_next   = cnt_reg;
        if (state_reg == CELL_IDLE && start)
        begin
            cnt_next = CNT_W'(OWED_W);
            if (denom_reg == '0)
            begin
                rem_next = DATA_W'(owed_in);
                quo_next = '0;
            end
            else
            begin
                rem_next = '0;
                quo_next = owed_in;
            end
        end
        else if (state_reg == CELL_DIV)
        begin
            cnt_next = cnt_reg - CNT_W'(1);
            quo_next = {quo_reg[OWED_W-2:0], fits};
            rem_next = fits ? trial[DATA_W-1:0] : {rem_reg[DATA_W-2:0], quo_reg[OWED_W-1]};
        end
    end

    // Outputs toward the collector
    always_comb
    begin
        res.hold  = (state_reg == CELL_HOLD);
        res.denom = denom_reg;
        res.count = DATA_W'(quo_reg);
        res.rem   = rem_reg;
    end

    // Control and configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= CELL_IDLE;
            cnt_reg   <= '0;
            denom_reg <= RESET_DENOM;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            denom_reg <= denom_next;
        end
    end

    // Division payload
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

endmodule

`default_nettype wire

FILE: design/gcm_checker.sv
// Port-level checks for the greedy change maker, bound to the top level.
`default_nettype none

module gcm_checker
    import gcm_pkg::*;
(
    input wire logic                   clk,
    input wire logic                   rst_n,
    input wire logic                   s_axis_tvalid,
    input wire logic                   s_axis_tready,
    input wire logic                   m_axis_tvalid,
    input wire logic                   m_axis_tready,
    input wire logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input wire logic                   m_axis_tlast
);

    // Hold a stalled result beat
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)
                                               && $stable(m_axis_tlast)))
        else $error("result beat changed while stalled");

    // Drop input ready once an amount is taken
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("second amount taken while one is in work");

    // A beat that is not final pays something and leaves unpaid at zero
    a_mid_beat: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tlast) |->
            (m_axis_tdata[DATA_W-1:0] != '0 && m_axis_tdata[2*DATA_W-1:DATA_W] != '0
             && m_axis_tdata[3*DATA_W-1:2*DATA_W] == '0))
        else $error("non-final beat with empty payout or unpaid amount");

    // A zero denomination only appears on an empty final beat
    a_empty_final: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tdata[DATA_W-1:0] == '0) |->
            (m_axis_tlast && m_axis_tdata[2*DATA_W-1:DATA_W] == '0))
        else $error("zero denomination with pieces or without last");

endmodule

bind greedy_change_maker_unit gcm_checker u_gcm_checker (.*);

`default_nettype wire

FILE: tb/gcm_payout_checker.sv
// Payout checker for the greedy change maker: predicts result beats and compares them.
`timescale 1ns / 1ps

module gcm_payout_checker
    import gcm_pkg::*;
#(
    parameter int NUM_DENOMINATIONS = DEFAULT_NUM_DENOMINATIONS,
    parameter int AMOUNT_WIDTH      = DEFAULT_AMOUNT_WIDTH
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_valid,
    input  logic                                  cfg_ready,
    input  logic [SLOT_IDX_W-1:0]                 cfg_index,
    input  logic [DATA_W-1:0]                     cfg_data,
    input  logic                                  s_axis_tvalid,
    input  logic                                  s_axis_tready,
    // amount
    input  logic [((AMOUNT_WIDTH+7)/8)*8-1:0]     s_axis_tdata,
    input  logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // denomination, piece_count, unpaid
    input  logic [OUT_TDATA_W-1:0]                m_axis_tdata,
    input  logic                                  m_axis_tlast,
    output int                                    pending_payouts,
    output int                                    mismatch_count
);

    // Amount is taken modulo 2^AMOUNT_WIDTH
    localparam logic [DATA_W-1:0] AMOUNT_MASK = (AMOUNT_WIDTH >= DATA_W) ?
        {DATA_W{1'b1}} : DATA_W'((64'd1 << AMOUNT_WIDTH) - 64'd1);

    typedef struct packed {
        logic [DATA_W-1:0] denomination;
        logic [DATA_W-1:0] piece_count;
        logic [DATA_W-1:0] unpaid;
        logic              last;
    } payout_beat_t;

    logic [DATA_W-1:0] denoms [NUM_SLOTS];
    payout_beat_t      expected_payouts [$];

    // Print one line per mismatch and count it
    task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                   input logic [DATA_W-1:0] want);
        $display("%0t mismatch: %s got 0x%08h expected 0x%08h", $time, what, got, want);
        mismatch_count++;
    endtask

    // Walk the slots in order and queue the beats one amount produces
    function automatic void predict_payout(input logic [DATA_W-1:0] amount);
        logic [DATA_W-1:0] owed;
        logic [DATA_W-1:0] pieces;
        payout_beat_t      beats [NUM_SLOTS];
        int                n;
        owed = amount & AMOUNT_MASK;
        n = 0;
        for (int k = 0; k < NUM_DENOMINATIONS && k < NUM_SLOTS; k++)
        begin
            if (denoms[k] != {DATA_W{1'b0}})
            begin
                pieces = owed / denoms[k];
                if (pieces != {DATA_W{1'b0}})
                begin
                    owed = owed - pieces * denoms[k];
                    beats[n].denomination = denoms[k];
                    beats[n].piece_count  = pieces;
                    beats[n].unpaid       = {DATA_W{1'b0}};
                    beats[n].last         = 1'b0;
                    n++;
                end
            end
        end
        // Nothing paid: a single closing beat with zero piece
        if (n == 0)
        begin
            beats[0].denomination = {DATA_W{1'b0}};
            beats[0].piece_count  = {DATA_W{1'b0}};
            n = 1;
        end
        beats[n-1].unpaid = owed;
        beats[n-1].last   = 1'b1;
        for (int k = 0; k < n; k++)
            expected_payouts = {expected_payouts, beats[k]};
    endfunction

    always @(posedge clk)
    begin
        payout_beat_t want;
        if (!rst_n)
        begin
            for (int k = 0; k < NUM_SLOTS; k++)
                denoms[k] = DENOM_RESET[k];
            expected_payouts.delete();
            mismatch_count = 0;
        end
        else
        begin
            // Track register writes
            if (cfg_valid && cfg_ready)
                denoms[cfg_index] = cfg_data;

            // Predict on every accepted amount beat
            if (s_axis_tvalid && s_axis_tready)
                predict_payout(s_axis_tdata[DATA_W-1:0]);

            // Compare every accepted result beat with the oldest expectation
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_payouts.size() == 0)
                    report_mismatch("unexpected result beat, denomination",
                                    m_axis_tdata[DATA_W-1:0], {DATA_W{1'b0}});
                else
                begin
                    want = expected_payouts.pop_front();
                    if (m_axis_tdata[DATA_W-1:0] !== want.denomination)
                        report_mismatch("denomination", m_axis_tdata[DATA_W-1:0],
                                        want.denomination);
                    if (m_axis_tdata[2*DATA_W-1:DATA_W] !== want.piece_count)
                        report_mismatch("piece_count", m_axis_tdata[2*DATA_W-1:DATA_W],
                                        want.piece_count);
                    if (m_axis_tdata[3*DATA_W-1:2*DATA_W] !== want.unpaid)
                        report_mismatch("unpaid", m_axis_tdata[3*DATA_W-1:2*DATA_W],
                                        want.unpaid);
                    if (m_axis_tlast !== want.last)
                        report_mismatch("tlast", DATA_W'(m_axis_tlast), DATA_W'(want.last));
                end
            end
        end
        pending_payouts = expected_payouts.size();
    end

endmodule

FILE: tb/greedy_change_maker_unit_tb.sv
// Testbench top for the greedy change maker: stimulus, back-pressure, watchdog and verdict.
`timescale 1ns / 1ps

module greedy_change_maker_unit_tb;
    import gcm_pkg::*;

    localparam int IN_TDATA_W     = ((DEFAULT_AMOUNT_WIDTH + 7) / 8) * 8;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int TAIL_CYCLES    = 300;
    localparam int NUM_PHASES     = 4;
    localparam int SETS_PER_PHASE = 3;
    localparam int ITEMS_PER_SET  = 29;
    localparam int SEND_IDLE  [NUM_PHASES] = '{0, 81, 0, 38};
    localparam int RECV_STALL [NUM_PHASES] = '{0, 0, 81, 38};

    typedef enum int {
        SET_CURRENCY,
        SET_GAPS,
        SET_UNORDERED,
        SET_ZERO,
        SET_MAX,
        SET_ONES,
        SET_UNIT_ONLY,
        SET_RANDOM
    } denom_set_t;

    logic                    clk;
    logic                    rst_n;
    logic                    cfg_valid;
    logic                    cfg_ready;
    logic [SLOT_IDX_W-1:0]   cfg_index;
    logic [DATA_W-1:0]       cfg_data;
    logic                    s_axis_tvalid;
    logic                    s_axis_tready;
    logic [IN_TDATA_W-1:0]   s_axis_tdata;
    logic                    m_axis_tvalid;
    logic                    m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0]  m_axis_tdata;
    logic                    m_axis_tlast;

    int                      pending_payouts;
    int                      mismatch_count;
    int                      send_idle_pct = 0;
    int                      recv_stall_pct = 0;
    int                      quiet_cycles;
    logic [DATA_W-1:0]       plan [NUM_SLOTS];

    greedy_change_maker_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    gcm_payout_checker payout_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .s_axis_tvalid   (s_axis_tvalid),
        .s_axis_tready   (s_axis_tready),
        .s_axis_tdata    (s_axis_tdata),
        .m_axis_tvalid   (m_axis_tvalid),
        .m_axis_tready   (m_axis_tready),
        .m_axis_tdata    (m_axis_tdata),
        .m_axis_tlast    (m_axis_tlast),
        .pending_payouts (pending_payouts),
        .mismatch_count  (mismatch_count)
    );

    // Free-running clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Stall the result side at random
    always @(negedge clk)
        m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);

    // End the run when no channel moves a beat for too long
    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Offer one amount beat, idling first at the phase's rate; valid stays high on exit
    task automatic send_amount(input logic [DATA_W-1:0] amount);
        if ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            do
                @(negedge clk);
            while ($urandom_range(0, 99) < send_idle_pct);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= IN_TDATA_W'(amount);
        do
            @(posedge clk);
        while (!s_axis_tready);
        @(negedge clk);
    endtask

    // Hold off the sender until every expected beat has come
    task automatic drain_payouts();
        s_axis_tvalid <= 1'b0;
        do
            @(negedge clk);
        while (pending_payouts != 0);
    endtask

    // Fill the plan with one denomination set
    task automatic pick_set(input denom_set_t kind);
        logic [DATA_W-1:0] tmp;
        case (kind)
            SET_CURRENCY:  plan = '{50000, 20000, 10000, 5000, 1000, 100, 25, 1};
            SET_GAPS:      plan = '{0, 7000, 0, 300, 0, 0, 9, 0};
            SET_UNORDERED: plan = '{5, 100, 100, 3, 1000, 0, 2, 7};
            SET_ZERO:      plan = '{0, 0, 0, 0, 0, 0, 0, 0};
            SET_MAX:
                for (int k = 0; k < NUM_SLOTS; k++)
                    plan[k] = {DATA_W{1'b1}};
            SET_ONES:      plan = '{1, 1, 1, 1, 1, 1, 1, 1};
            SET_UNIT_ONLY: plan = DENOM_RESET;
            default:
            begin
                for (int k = 0; k < NUM_SLOTS; k++)
                    case ($urandom_range(0, 3))
                        0:       plan[k] = '0;
                        1:       plan[k] = $urandom;
                        2:       plan[k] = $urandom_range(1, 1000);
                        default: plan[k] = $urandom >> $urandom_range(0, 31);
                    endcase
                // Sort descending half of the time
                if ($urandom_range(0, 1) == 1)
                    for (int i = 0; i < NUM_SLOTS - 1; i++)
                        for (int j = 0; j < NUM_SLOTS - 1 - i; j++)
                            if (plan[j] < plan[j+1])
                            begin
                                tmp       = plan[j];
                                plan[j]   = plan[j+1];
                                plan[j+1] = tmp;
                            end
            end
        endcase
    endtask

    // Drain, then write all eight denomination registers back to back
    task automatic reconfigure(input denom_set_t kind);
        drain_payouts();
        pick_set(kind);
        for (int k = 0; k < NUM_SLOTS; k++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= SLOT_IDX_W'(k);
            cfg_data  <= plan[k];
            do
                @(posedge clk);
            while (!cfg_ready);
            @(negedge clk);
        end
        cfg_valid <= 1'b0;
    endtask

    // Mix of full-range, small and near-denomination amounts
    function automatic logic [DATA_W-1:0] random_amount();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return $urandom;
            4, 5:       return $urandom_range(0, 1000);
            6:          return plan[$urandom_range(0, NUM_SLOTS - 1)] * $urandom_range(1, 20)
                               + $urandom_range(0, 3);
            7:          return ($urandom_range(0, 1) == 1) ? {DATA_W{1'b1}} : '0;
            default:    return $urandom_range(0, 1000000);
        endcase
    endfunction

    initial
    begin
        rst_n         = 1'b0;
        cfg_valid     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: reset denominations, only the unit piece
        pick_set(SET_UNIT_ONLY);
        send_amount(32'd0);
        send_amount(32'd5);
        send_amount(32'hFFFF_FFFF);

        // Directed: descending currency set, extremes and exact hits
        reconfigure(SET_CURRENCY);
        send_amount(32'd0);
        send_amount(32'd1);
        send_amount(32'hFFFF_FFFF);
        send_amount(32'h8000_0000);
        send_amount(32'd50000);
        send_amount(32'd49999);
        send_amount(32'd88888);
        send_amount(32'd126);

        // Directed: unused slots, leftover below the smallest piece
        reconfigure(SET_GAPS);
        send_amount(32'd8);
        send_amount(32'd7000);
        send_amount(32'd7308);
        send_amount(32'd1234567);

        // Directed: slots out of order with a repeated denomination
        reconfigure(SET_UNORDERED);
        send_amount(32'd1000);
        send_amount(32'd107);

        // Directed: nothing configured, then the largest pieces, then unit pieces
        reconfigure(SET_ZERO);
        send_amount(32'd42);
        send_amount(32'hFFFF_FFFF);
        reconfigure(SET_MAX);
        send_amount(32'hFFFF_FFFF);
        send_amount(32'hFFFF_FFFE);
        reconfigure(SET_ONES);
        send_amount(32'hFFFF_FFFF);
        send_amount(32'd77);

        // Random: each idling phase runs over several denomination sets
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            send_idle_pct  = SEND_IDLE[p];
            recv_stall_pct = RECV_STALL[p];
            for (int b = 0; b < SETS_PER_PHASE; b++)
            begin
                if ($urandom_range(0, 1) == 1)
                    reconfigure(SET_RANDOM);
                else
                    reconfigure(denom_set_t'($urandom_range(SET_CURRENCY, SET_UNIT_ONLY)));
                for (int i = 0; i < ITEMS_PER_SET; i++)
                begin
                    send_amount(random_amount());
                    if ($urandom_range(0, 19) == 0)
                        drain_payouts();
                end
            end
        end

        // Wait out the last results, then a tail for stray beats
        drain_payouts();
        repeat (TAIL_CYCLES) @(negedge clk);
        if (mismatch_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

FILE: filelist.f
design/gcm_pkg.sv
design/gcm_cell.sv
design/greedy_change_maker_unit.sv
design/gcm_checker.sv
tb/gcm_payout_checker.sv
tb/greedy_change_maker_unit_tb.sv
